>>> hdl/rmst_pkg.sv
// Package: shared types, constants and helpers of the range maximum segment tree.
`default_nettype none

package rmst_pkg;

  // Field widths fixed by the item format
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;

  // Default sizing
  localparam int unsigned RMST_CAPACITY     = 1024;
  localparam int unsigned RMST_MAX_ADD_SPAN = 10;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [0:0]  REG_ELEMENT_COUNT = 1'b0;
  localparam logic [IDX_W-1:0] ELEMENT_COUNT_RST = 11'd1024;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         last_index;
    logic signed [DATA_W-1:0] operand_value;
  } rmst_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] max_value;
    logic                     bad_range;
  } rmst_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the input beat
    logic clr_step;    // write zero at the clear pointer and advance
    logic load_wr;     // write the operand to the leaf, start the climb
    logic leaf_rd;     // read the current leaf
    logic leaf_wr;     // write leaf plus operand, start the climb
    logic leaf_next;   // advance to the next leaf of a range add
    logic sib_rd;      // read the sibling of the current node
    logic par_wr;      // write the parent maximum and move up
    logic q_init_rd;   // read the left border node
    logic q_init_take; // seed the running maximum
    logic q_a_rd;      // read the left node and step the left border
    logic q_a_take;    // fold the left node into the maximum
    logic q_b_rd;      // step the right border and read it
    logic q_b_take;    // fold the right node into the maximum
    logic q_shift;     // move both borders up one level
    logic res_ok;      // load a query result into the output register
    logic res_bad;     // load a range error into the output register
  } rmst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             load_ok;
    logic             add_ok;
    logic             query_ok;
    logic             clr_last;
    logic             node_root;
    logic             leaf_last;
    logic             a_lt_b;
    logic             a_odd;
    logic             b_odd;
    logic             out_free;
  } rmst_status_t;

  // Signed maximum
  function automatic logic signed [DATA_W-1:0] smax(input logic signed [DATA_W-1:0] x,
                                                    input logic signed [DATA_W-1:0] y);
    return (x >= y) ? x : y;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rmst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rmst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/rmst_datapath.sv
// Datapath: item registers, tree pointers, running maximum, node store and result register.
`default_nettype none

module rmst_datapath #(
  parameter int unsigned CAPACITY     = rmst_pkg::RMST_CAPACITY,
  parameter int unsigned MAX_ADD_SPAN = rmst_pkg::RMST_MAX_ADD_SPAN
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [rmst_pkg::IDX_W-1:0]  element_count_i,
  input  wire rmst_pkg::rmst_in_t          in_data_i,
  input  wire logic                        out_stall_i,
  input  wire rmst_pkg::rmst_cmd_t         cmd_i,
  output rmst_pkg::rmst_status_t           status_o,
  output logic                             out_valid_o,
  output rmst_pkg::rmst_out_t              out_data_o
);
  import rmst_pkg::*;

  localparam int unsigned Depth = 2 * CAPACITY;
  localparam int unsigned NW    = $clog2(Depth);
  localparam logic [31:0] Base  = 32'(CAPACITY);
  localparam logic [31:0] Span  = 32'(MAX_ADD_SPAN);

  // Item registers
  logic [CMD_W-1:0]         cmd_q;
  logic [IDX_W-1:0]         first_q, last_q;
  logic signed [DATA_W-1:0] operand_q;

  // Tree pointers and values
  logic [NW-1:0]            leaf_q, leaf_d, leaf_end_q;
  logic [NW-1:0]            node_q, node_d;
  logic [NW-1:0]            clr_q, clr_d;
  logic [NW:0]              a_q, a_d, b_q, b_d;
  logic signed [DATA_W-1:0] cur_q, cur_d;
  logic signed [DATA_W-1:0] best_q, best_d;

  // Result register
  logic                     out_valid_q, out_valid_d;
  rmst_out_t                out_q, out_d;

  // Memory port
  logic                     we;
  logic [NW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] wdata;
  logic [DATA_W-1:0]        rdata_raw;
  logic signed [DATA_W-1:0] rdata;

  // Wide helpers for address and range arithmetic
  logic [31:0] in_first32, in_last32, lo_node32, hi_node32, end_node32;
  logic [31:0] first32, last32, count32, lim32;
  logic [NW:0] b_dec;
  logic signed [DATA_W-1:0] leaf_sum, climb_max;

  assign rdata = $signed(rdata_raw);

  // Leaf addresses of a fresh beat
  assign in_first32 = {{(32-IDX_W){1'b0}}, in_data_i.first_index};
  assign in_last32  = {{(32-IDX_W){1'b0}}, in_data_i.last_index};
  assign lo_node32  = Base + in_first32 - 32'd1;
  assign end_node32 = Base + in_last32 - 32'd1;
  assign hi_node32  = Base + in_last32;

  // Range checks on the captured item
  assign first32 = {{(32-IDX_W){1'b0}}, first_q};
  assign last32  = {{(32-IDX_W){1'b0}}, last_q};
  assign count32 = {{(32-IDX_W){1'b0}}, element_count_i};
  assign lim32   = (count32 > Base) ? Base : count32;

  assign b_dec     = b_q - (NW+1)'(1);
  assign leaf_sum  = rdata + operand_q;
  assign climb_max = smax(cur_q, rdata);

  always_comb begin
    status_o.command   = cmd_q;
    status_o.load_ok   = (first32 >= 32'd1) && (first32 <= lim32);
    status_o.query_ok  = (first32 >= 32'd1) && (first32 <= last32) && (last32 <= lim32);
    status_o.add_ok    = status_o.query_ok && ((last32 - first32 + 32'd1) <= Span);
    status_o.clr_last  = (clr_q == NW'(Depth - 1));
    status_o.node_root = (node_q == NW'(1));
    status_o.leaf_last = (leaf_q == leaf_end_q);
    status_o.a_lt_b    = (a_q < b_q);
    status_o.a_odd     = a_q[0];
    status_o.b_odd     = b_q[0];
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Read address select
  always_comb begin
    raddr = leaf_q;
    if (cmd_i.leaf_rd) begin
      raddr = leaf_q;
    end else if (cmd_i.sib_rd) begin
      raddr = {node_q[NW-1:1], ~node_q[0]};
    end else if (cmd_i.q_init_rd || cmd_i.q_a_rd) begin
      raddr = a_q[NW-1:0];
    end else if (cmd_i.q_b_rd) begin
      raddr = b_dec[NW-1:0];
    end
  end

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = leaf_q;
    wdata = operand_q;
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (cmd_i.load_wr) begin
      we    = 1'b1;
    end else if (cmd_i.leaf_wr) begin
      we    = 1'b1;
      wdata = leaf_sum;
    end else if (cmd_i.par_wr) begin
      we    = 1'b1;
      waddr = node_q >> 1;
      wdata = climb_max;
    end
  end

  // Pointer and value updates
  always_comb begin
    leaf_d = leaf_q;
    node_d = node_q;
    clr_d  = clr_q;
    a_d    = a_q;
    b_d    = b_q;
    cur_d  = cur_q;
    best_d = best_q;
    if (cmd_i.capture) begin
      leaf_d = lo_node32[NW-1:0];
      a_d    = lo_node32[NW:0];
      b_d    = hi_node32[NW:0];
    end
    if (cmd_i.clr_step) begin
      clr_d = clr_q + NW'(1);
    end
    if (cmd_i.load_wr) begin
      node_d = leaf_q;
      cur_d  = operand_q;
    end
    if (cmd_i.leaf_wr) begin
      node_d = leaf_q;
      cur_d  = leaf_sum;
    end
    if (cmd_i.leaf_next) begin
      leaf_d = leaf_q + NW'(1);
    end
    if (cmd_i.par_wr) begin
      node_d = node_q >> 1;
      cur_d  = climb_max;
    end
    if (cmd_i.q_init_take) begin
      best_d = rdata;
    end
    if (cmd_i.q_a_rd) begin
      a_d = a_q + (NW+1)'(1);
    end
    if (cmd_i.q_b_rd) begin
      b_d = b_dec;
    end
    if (cmd_i.q_a_take || cmd_i.q_b_take) begin
      best_d = smax(best_q, rdata);
    end
    if (cmd_i.q_shift) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
    end
  end

  // Result register: load on a result, drop once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.res_ok) begin
      out_valid_d     = 1'b1;
      out_d.max_value = best_q;
      out_d.bad_range = 1'b0;
    end else if (cmd_i.res_bad) begin
      out_valid_d     = 1'b1;
      out_d.max_value = '0;
      out_d.bad_range = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q      <= in_data_i.command;
      first_q    <= in_data_i.first_index;
      last_q     <= in_data_i.last_index;
      operand_q  <= in_data_i.operand_value;
      leaf_end_q <= end_node32[NW-1:0];
    end
    leaf_q <= leaf_d;
    node_q <= node_d;
    a_q    <= a_d;
    b_q    <= b_d;
    cur_q  <= cur_d;
    best_q <= best_d;
    out_q  <= out_d;
  end

  rmst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (Depth)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/rmst_ctrl.sv
// Controller: sequences clearing, loads, range adds and range queries.
`default_nettype none

module rmst_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire rmst_pkg::rmst_status_t status_i,
  output rmst_pkg::rmst_cmd_t         cmd_o
);
  import rmst_pkg::*;

  localparam logic [4:0] S_CLEAR       = 5'd0;
  localparam logic [4:0] S_IDLE        = 5'd1;
  localparam logic [4:0] S_DECODE      = 5'd2;
  localparam logic [4:0] S_LOAD_WR     = 5'd3;
  localparam logic [4:0] S_LEAF_RD     = 5'd4;
  localparam logic [4:0] S_LEAF_WR     = 5'd5;
  localparam logic [4:0] S_SIB_RD      = 5'd6;
  localparam logic [4:0] S_PAR_WR      = 5'd7;
  localparam logic [4:0] S_Q_INIT_RD   = 5'd8;
  localparam logic [4:0] S_Q_INIT_TAKE = 5'd9;
  localparam logic [4:0] S_Q_TEST      = 5'd10;
  localparam logic [4:0] S_Q_A_TAKE    = 5'd11;
  localparam logic [4:0] S_Q_B_TEST    = 5'd12;
  localparam logic [4:0] S_Q_B_TAKE    = 5'd13;
  localparam logic [4:0] S_Q_SHIFT     = 5'd14;
  localparam logic [4:0] S_RES_OK      = 5'd15;
  localparam logic [4:0] S_RES_BAD     = 5'd16;

  logic [4:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.command)
          CMD_LOAD:  state_d = status_i.load_ok  ? S_LOAD_WR   : S_RES_BAD;
          CMD_ADD:   state_d = status_i.add_ok   ? S_LEAF_RD   : S_RES_BAD;
          CMD_QUERY: state_d = status_i.query_ok ? S_Q_INIT_RD : S_RES_BAD;
          CMD_NONE:  state_d = S_IDLE;
          default:   state_d = S_IDLE;
        endcase
      end
      S_LOAD_WR: begin
        cmd_o.load_wr = 1'b1;
        state_d       = S_SIB_RD;
      end
      S_LEAF_RD: begin
        cmd_o.leaf_rd = 1'b1;
        state_d       = S_LEAF_WR;
      end
      S_LEAF_WR: begin
        cmd_o.leaf_wr = 1'b1;
        state_d       = S_SIB_RD;
      end
      S_SIB_RD: begin
        // At the root the climb is over: next leaf of an add, or done
        if (status_i.node_root) begin
          if (status_i.command == CMD_ADD && !status_i.leaf_last) begin
            cmd_o.leaf_next = 1'b1;
            state_d         = S_LEAF_RD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.sib_rd = 1'b1;
          state_d      = S_PAR_WR;
        end
      end
      S_PAR_WR: begin
        cmd_o.par_wr = 1'b1;
        state_d      = S_SIB_RD;
      end
      S_Q_INIT_RD: begin
        cmd_o.q_init_rd = 1'b1;
        state_d         = S_Q_INIT_TAKE;
      end
      S_Q_INIT_TAKE: begin
        cmd_o.q_init_take = 1'b1;
        state_d           = S_Q_TEST;
      end
      S_Q_TEST: begin
        if (!status_i.a_lt_b) begin
          state_d = S_RES_OK;
        end else if (status_i.a_odd) begin
          cmd_o.q_a_rd = 1'b1;
          state_d      = S_Q_A_TAKE;
        end else begin
          state_d = S_Q_B_TEST;
        end
      end
      S_Q_A_TAKE: begin
        cmd_o.q_a_take = 1'b1;
        state_d        = S_Q_B_TEST;
      end
      S_Q_B_TEST: begin
        if (status_i.b_odd) begin
          cmd_o.q_b_rd = 1'b1;
          state_d      = S_Q_B_TAKE;
        end else begin
          state_d = S_Q_SHIFT;
        end
      end
      S_Q_B_TAKE: begin
        cmd_o.q_b_take = 1'b1;
        state_d        = S_Q_SHIFT;
      end
      S_Q_SHIFT: begin
        cmd_o.q_shift = 1'b1;
        state_d       = S_Q_TEST;
      end
      S_RES_OK: begin
        if (status_i.out_free) begin
          cmd_o.res_ok = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_RES_BAD: begin
        if (status_i.out_free) begin
          cmd_o.res_bad = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/range_max_segment_tree.sv
// Top level: configuration register, controller and datapath of the range maximum tree.
//
//   channel   direction  handshake                     payload
//   in        input      in_valid_i / in_stall_o       in_data_i  (rmst_in_t)
//   out       output     out_valid_o / out_stall_i     out_data_o (rmst_out_t)
//   config    input      psel/penable/pwrite/pready    paddr_i, pwdata_i, prdata_o
//
// One item at a time through a one-write, one-read node RAM. A load writes the leaf and then
// climbs to the root; a range add reads, writes and climbs from each element of the range in
// turn; a query walks the left and right borders up the tree, folding in the nodes it passes.
// After reset a clearing pass writes all 2*CAPACITY nodes, one per cycle, with in_stall_o
// high. A result waiting on out_stall_i holds only the next item that gives a result.
`default_nettype none

module range_max_segment_tree #(
  parameter int unsigned CAPACITY     = rmst_pkg::RMST_CAPACITY,
  parameter int unsigned MAX_ADD_SPAN = rmst_pkg::RMST_MAX_ADD_SPAN
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire rmst_pkg::rmst_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output rmst_pkg::rmst_out_t                out_data_o,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [rmst_pkg::PADDR_W-1:0]  paddr_i,
  input  wire logic [rmst_pkg::PDATA_W-1:0]  pwdata_i,
  output logic      [rmst_pkg::PDATA_W-1:0]  prdata_o,
  output logic                               pready_o
);
  import rmst_pkg::*;

  logic [IDX_W-1:0] element_count_q, element_count_d;
  logic             reg_hit;
  rmst_cmd_t        cmd;
  rmst_status_t     status;

  // Register decode
  assign pready_o = 1'b1;
  assign reg_hit  = (paddr_i[PADDR_W-1:2] == REG_ELEMENT_COUNT);

  always_comb begin
    element_count_d = element_count_q;
    if (psel_i && penable_i && pwrite_i && pready_o && reg_hit) begin
      element_count_d = pwdata_i[IDX_W-1:0];
    end
  end

  assign prdata_o = reg_hit ? {{(PDATA_W-IDX_W){1'b0}}, element_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_count_q <= ELEMENT_COUNT_RST;
    end else begin
      element_count_q <= element_count_d;
    end
  end

  rmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmst_datapath #(
    .CAPACITY     (CAPACITY),
    .MAX_ADD_SPAN (MAX_ADD_SPAN)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_count_i (element_count_q),
    .in_data_i       (in_data_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_data_o      (out_data_o)
  );

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for range_max_segment_tree: loads, range adds and range max queries.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmst_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned IDLE_PCT      = 38;
  localparam int unsigned PHASES        = 8;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  rmst_in_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rmst_out_t           out_data_o;
  logic                psel_i      = 1'b0;
  logic                penable_i   = 1'b0;
  logic                pwrite_i    = 1'b0;
  logic [PADDR_W-1:0]  paddr_i     = '0;
  logic [PDATA_W-1:0]  pwdata_i    = '0;
  logic [PDATA_W-1:0]  prdata_o;
  logic                pready_o;

  // Shadow of the block: leaf values and the element count register
  logic signed [DATA_W-1:0] leaf_val [1:RMST_CAPACITY];
  logic [IDX_W-1:0]         count_reg = ELEMENT_COUNT_RST;

  rmst_in_t    pending_beats[$];
  rmst_out_t   expected_max[$];
  bit          beat_taken   = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned err_count    = 0;
  int unsigned settings_run = 0;

  range_max_segment_tree dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel_i      (psel_i),
    .penable_i   (penable_i),
    .pwrite_i    (pwrite_i),
    .paddr_i     (paddr_i),
    .pwdata_i    (pwdata_i),
    .prdata_o    (prdata_o),
    .pready_o    (pready_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int unsigned count_limit();
    return (count_reg > RMST_CAPACITY) ? RMST_CAPACITY : int'(count_reg);
  endfunction

  // Apply one beat to the shadow tree and queue the result it causes
  task automatic predict_beat(input rmst_in_t beat);
    int unsigned lim;
    int unsigned lo;
    int unsigned hi;
    bit range_ok;
    logic signed [DATA_W-1:0] best;
    rmst_out_t res;
    lim = count_limit();
    lo = beat.first_index;
    hi = beat.last_index;
    range_ok = (lo >= 1) && (lo <= hi) && (hi <= lim);
    res.max_value = '0;
    res.bad_range = 1'b1;
    case (beat.command)
      CMD_LOAD: begin
        if (lo >= 1 && lo <= lim) begin
          leaf_val[lo] = beat.operand_value;
          return;
        end
      end
      CMD_ADD: begin
        if (range_ok && (hi - lo + 1) <= RMST_MAX_ADD_SPAN) begin
          for (int unsigned i = lo; i <= hi; i++) leaf_val[i] = leaf_val[i] + beat.operand_value;
          return;
        end
      end
      CMD_QUERY: begin
        if (range_ok) begin
          best = leaf_val[lo];
          for (int unsigned i = lo + 1; i <= hi; i++) if (leaf_val[i] > best) best = leaf_val[i];
          res.max_value = best;
          res.bad_range = 1'b0;
        end
      end
      default: return;
    endcase
    expected_max.push_back(res);
  endtask

  // Monitor: check result beats, then predict accepted input beats
  always @(posedge clk_i) begin
    rmst_out_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_max.size() == 0) begin
          report_mismatch($sformatf("unexpected result max=%0d bad=%0b",
                                    out_data_o.max_value, out_data_o.bad_range));
        end else begin
          exp_res = expected_max.pop_front();
          if (out_data_o.max_value !== exp_res.max_value)
            report_mismatch($sformatf("result %0d max_value %0d, want %0d", results_seen,
                                      out_data_o.max_value, exp_res.max_value));
          if (out_data_o.bad_range !== exp_res.bad_range)
            report_mismatch($sformatf("result %0d bad_range %0b, want %0b", results_seen,
                                      out_data_o.bad_range, exp_res.bad_range));
        end
      end
      beat_taken = in_valid_i && !in_stall_o;
      if (beat_taken) begin
        beats_sent++;
        predict_beat(in_data_i);
      end
    end
  end

  // Driver: offer the next pending beat, idling at random outside the steady window
  always @(negedge clk_i) begin
    bit steady;
    steady = (beats_sent >= 400) && (beats_sent < 520);
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      if (pending_beats.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data_i  <= pending_beats.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a window with no stalls
  always @(negedge clk_i) begin
    bit stall;
    if (hold_left > 0) begin
      hold_left--;
      stall = 1'b1;
    end else if (!hold_done && results_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      stall = 1'b1;
    end else if (results_seen >= 150 && results_seen < 220) begin
      stall = 1'b0;
    end else begin
      stall = ($urandom_range(0, 99) < IDLE_PCT);
    end
    out_stall_i <= stall;
  end

  // One register access: setup cycle, then access cycle until pready
  task automatic reg_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= wr;
    paddr_i   <= addr;
    pwdata_i  <= wdata;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    rdata = prdata_o;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // Write element_count, mirror it, and read it back
  task automatic set_count(input logic [IDX_W-1:0] cnt);
    logic [PDATA_W-1:0] word;
    logic [PDATA_W-1:0] rd;
    word = {(PDATA_W-IDX_W)'($urandom()), cnt};
    reg_access(1'b1, PADDR_W'(4 * REG_ELEMENT_COUNT), word, rd);
    count_reg = cnt;
    settings_run++;
    reg_access(1'b0, PADDR_W'(4 * REG_ELEMENT_COUNT), '0, rd);
    if (rd !== PDATA_W'(cnt))
      report_mismatch($sformatf("element_count reads %0h, want %0h", rd, cnt));
  endtask

  // Hold the sender until every result is in, then let trailing work finish
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_max.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return DATA_W'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom();
    endcase
  endfunction

  function automatic rmst_in_t make_beat(input int unsigned lim);
    rmst_in_t beat;
    int unsigned sel;
    int unsigned room;
    int unsigned span;
    beat.operand_value = rand_operand();
    sel = $urandom_range(0, 99);
    beat.command = (sel < 30) ? CMD_LOAD : (sel < 60) ? CMD_ADD : (sel < 95) ? CMD_QUERY : CMD_NONE;
    if (lim == 0 || $urandom_range(0, 99) < 20) begin
      // Noise: any index pattern, mostly invalid
      beat.first_index = IDX_W'($urandom());
      beat.last_index  = IDX_W'($urandom());
    end else begin
      // Well-formed range, biased toward the low end so values accumulate
      if (lim > 64 && $urandom_range(0, 99) < 50) beat.first_index = IDX_W'($urandom_range(1, 64));
      else beat.first_index = IDX_W'($urandom_range(1, lim));
      room = lim - beat.first_index + 1;
      case (beat.command)
        CMD_ADD: begin
          if (room > RMST_MAX_ADD_SPAN && $urandom_range(0, 99) < 8) span = RMST_MAX_ADD_SPAN + 1;
          else span = $urandom_range(1, (room < RMST_MAX_ADD_SPAN) ? room : RMST_MAX_ADD_SPAN);
        end
        CMD_QUERY: begin
          if ($urandom_range(0, 99) < 20) span = room;
          else span = $urandom_range(1, (room < 32) ? room : 32);
        end
        default: span = $urandom_range(1, room);
      endcase
      beat.last_index = IDX_W'(beat.first_index + span - 1);
    end
    return beat;
  endfunction

  function automatic rmst_in_t beat_of(input logic [CMD_W-1:0] cmd, input int unsigned lo,
                                       input int unsigned hi, input logic signed [DATA_W-1:0] v);
    rmst_in_t beat;
    beat.command       = cmd;
    beat.first_index   = IDX_W'(lo);
    beat.last_index    = IDX_W'(hi);
    beat.operand_value = v;
    return beat;
  endfunction

  initial begin
    int unsigned phase_count [PHASES] = '{1, 0, 2047, 10, 37, 1024, 0, 512};
    int unsigned phase_beats [PHASES] = '{100, 30, 160, 120, 130, 160, 130, 120};
    int unsigned cnt;
    foreach (leaf_val[i]) leaf_val[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    // Let the clearing pass finish before touching the register
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    set_count(ELEMENT_COUNT_RST);

    // Directed: extremes, wrap, negative maxima and every kind of bad range
    pending_beats.push_back(beat_of(CMD_QUERY, 1, 1024, 0));
    pending_beats.push_back(beat_of(CMD_LOAD, 1, 0, 32'sh7fff_ffff));
    pending_beats.push_back(beat_of(CMD_LOAD, 1024, 1, 32'sh8000_0000));
    pending_beats.push_back(beat_of(CMD_QUERY, 1, 1, 0));
    pending_beats.push_back(beat_of(CMD_QUERY, 1024, 1024, 0));
    pending_beats.push_back(beat_of(CMD_ADD, 1, 1, 32'sd1));
    pending_beats.push_back(beat_of(CMD_QUERY, 1, 1, 0));
    pending_beats.push_back(beat_of(CMD_QUERY, 1, 1024, 0));
    pending_beats.push_back(beat_of(CMD_LOAD, 5, 2047, -32'sd5));
    pending_beats.push_back(beat_of(CMD_LOAD, 6, 0, -32'sd3));
    pending_beats.push_back(beat_of(CMD_QUERY, 5, 6, 0));
    pending_beats.push_back(beat_of(CMD_ADD, 1015, 1024, 32'sd7));
    pending_beats.push_back(beat_of(CMD_QUERY, 1015, 1024, 0));
    pending_beats.push_back(beat_of(CMD_ADD, 1, 11, 32'sd9));
    pending_beats.push_back(beat_of(CMD_ADD, 3, 2, 32'sd9));
    pending_beats.push_back(beat_of(CMD_QUERY, 0, 5, 0));
    pending_beats.push_back(beat_of(CMD_QUERY, 7, 6, 0));
    pending_beats.push_back(beat_of(CMD_QUERY, 1, 1025, 0));
    pending_beats.push_back(beat_of(CMD_LOAD, 0, 0, 32'sd4));
    pending_beats.push_back(beat_of(CMD_LOAD, 1025, 0, 32'sd4));
    pending_beats.push_back(beat_of(CMD_LOAD, 2047, 2047, 32'sd4));
    pending_beats.push_back(beat_of(CMD_QUERY, 2047, 2047, -32'sd1));
    pending_beats.push_back(beat_of(CMD_NONE, 2047, 2047, 32'sh8000_0000));
    pending_beats.push_back(beat_of(CMD_QUERY, 1, 6, 0));
    wait_drained();

    // Random phases, each under its own element count
    for (int p = 0; p < PHASES; p++) begin
      cnt = (p == 6) ? $urandom_range(2, 1023) : phase_count[p];
      set_count(IDX_W'(cnt));
      for (int n = 0; n < phase_beats[p]; n++) pending_beats.push_back(make_beat(count_limit()));
      wait_drained();
    end

    $display("Covered %0d input beats and %0d results under %0d element_count settings,",
             beats_sent, results_seen, settings_run);
    $display("including zero, one and saturated counts, wrapping adds and a long output hold-off.");
    if (err_count == 0) begin
      $display("range_max_segment_tree regression: pass");
    end else begin
      $display("range_max_segment_tree regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("range_max_segment_tree regression: fail");
    $finish;
  end

endmodule
